// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FFA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ffa_pkg.sv
// shared constants and codes of the first-fit allocator
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;
	localparam int HEAP_BYTES_DEF = 65536;
	localparam int FREE_SLOTS_DEF = 64;
	localparam int MIN_GROW_DEF   = 8192;
	localparam int START_W        = 16;
	localparam int SIZE_W         = 17;
	localparam int ENT_W          = START_W + SIZE_W;
	localparam int KEEP_MIN       = 12;

	typedef enum logic [1:0] {
		ACT_ALLOC    = 2'd0,
		ACT_FREE     = 2'd1,
		ACT_COALESCE = 2'd2,
		ACT_READ     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EXHAUSTED  = 2'd1,
		ST_TABLE_FULL = 2'd2
	} status_t;
endpackage
`default_nettype wire

// File: rtl/ffa_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/first_fit_free_list_allocator.sv
// top level: first-fit free-list allocator with coalescing
// throughput: one request at a time; the next is taken while a result waits at the output
// reset: asynchronous, active low; clears count, heap break, limit (to 65536) and handshake
// the entry and header rams are not cleared: only written entries of the entry ram are ever read
`timescale 1ns / 1ps
`default_nettype none
module first_fit_free_list_allocator
	import ffa_pkg::*;
#(
	parameter int HEAP_BYTES     = HEAP_BYTES_DEF,
	parameter int FREE_SLOTS     = FREE_SLOTS_DEF,
	parameter int MIN_GROW_BYTES = MIN_GROW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] request_bytes,
	input  wire logic [15:0] user_address,
	input  wire logic [5:0]  list_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      result_address,
	output logic [16:0]      result_bytes,
	output logic             entry_valid,
	output logic [1:0]       status,
	output logic [6:0]       free_entries
);
	localparam int HDR_DEPTH = HEAP_BYTES / 8;
	localparam int HDR_AW    = $clog2(HDR_DEPTH);
	localparam int IDX_W     = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int CNT_W     = $clog2(FREE_SLOTS + 1);
	localparam int BRK_W     = $clog2(HEAP_BYTES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ALLOC_SCAN, S_ALLOC_SHIFT, S_ALLOC_GROW, S_FREE_RD, S_FREE_WR,
		S_READ_RD, S_READ_WR, S_CO_FIND, S_CO_PACK, S_DONE
	} state_t;

	state_t state_q;

	// architectural state
	logic [CNT_W-1:0] cnt_q;
	logic [BRK_W-1:0] brk_q;
	logic [16:0]      limit_q;

	// request held during the work
	logic [16:0]      need_q;
	logic [15:0]      fstart_q;
	logic [IDX_W-1:0] idx_q;

	// scan pipeline over the entry ram
	logic [CNT_W-1:0] scan_q;
	logic             rd_v_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	// coalesce walk in address order
	logic             first_q;
	logic [15:0]      prev_s_q;
	logic [IDX_W-1:0] prev_idx_q;
	logic             best_v_q;
	logic [15:0]      best_s_q;
	logic [16:0]      best_z_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [15:0]      cur_s_q;
	logic [16:0]      cur_z_q;
	logic [IDX_W-1:0] cur_idx_q;
	logic [FREE_SLOTS-1:0] keep_q;
	logic [CNT_W-1:0] wr_ptr_q;

	// pending result and output register
	logic [15:0] r_addr_q;
	logic [16:0] r_bytes_q;
	logic        r_valid_q;
	status_t     r_stat_q;
	logic        out_valid_q;
	logic [15:0] o_addr_q;
	logic [16:0] o_bytes_q;
	logic        o_valid_q;
	logic [1:0]  o_stat_q;
	logic [6:0]  o_free_q;

	// ram ports
	logic             ent_we;
	logic [IDX_W-1:0] ent_waddr;
	logic [ENT_W-1:0] ent_wdata;
	logic [IDX_W-1:0] ent_raddr;
	logic [ENT_W-1:0] ent_rdata;
	logic             hdr_we;
	logic [HDR_AW-1:0] hdr_waddr;
	logic [16:0]      hdr_wdata;
	logic [HDR_AW-1:0] hdr_raddr;
	logic [16:0]      hdr_rdata;

	// combinational decisions
	logic [15:0] rd_start;
	logic [16:0] rd_size;
	logic        scanning;
	logic        issue;
	logic        last;
	logic        hit;
	logic [16:0] rem;
	logic        hsplit;
	logic [31:0] bstart_h;
	logic [31:0] grow32;
	logic [31:0] lim32;
	logic        over;
	logic        gsplit;
	logic        gfull;
	logic [31:0] bstart_g;
	logic [16:0] bsize_g;
	logic [31:0] hidx;
	logic [31:0] need32;
	logic [31:0] fidx;
	logic        gt;
	logic        better;
	logic        b_v;
	logic [15:0] b_s;
	logic [16:0] b_z;
	logic [IDX_W-1:0] b_idx;
	logic [17:0] cur_end;
	logic        adj;
	logic [17:0] msum;
	logic [16:0] msat;
	logic [CNT_W-1:0] cnt_m1;
	logic [31:0] cnt32;

	assign rd_start = ent_rdata[ENT_W-1:SIZE_W];
	assign rd_size  = ent_rdata[SIZE_W-1:0];
	assign cnt_m1   = cnt_q - 1'b1;
	assign cnt32    = 32'(cnt_q);
	assign last     = rd_v_s1 && (CNT_W'(rd_idx_s1) == cnt_m1);

	// block size asked for: rounded to 8 plus the header
	assign need32 = 32'(((17'(request_bytes) + 17'd7) & ~17'd7) + 17'd8);
	assign fidx   = 32'(user_address - 16'd8) >> 3;

	// first fit on the returned entry
	assign hit      = (state_q == S_ALLOC_SCAN) && rd_v_s1 && (rd_size >= need_q);
	assign rem      = rd_size - need_q;
	assign hsplit   = 32'(rem) >= KEEP_MIN;
	assign bstart_h = 32'(rd_start) + (hsplit ? 32'(rem) : 32'd0);

	// heap growth when nothing fits
	assign grow32   = (32'(need_q) > MIN_GROW_BYTES) ? 32'(need_q) : MIN_GROW_BYTES;
	assign lim32    = (32'(limit_q) < HEAP_BYTES) ? 32'(limit_q) : HEAP_BYTES;
	assign over     = (32'(brk_q) + grow32) > lim32;
	assign gsplit   = (grow32 - 32'(need_q)) >= KEEP_MIN;
	assign gfull    = gsplit && (cnt32 >= FREE_SLOTS);
	assign bstart_g = gsplit ? (32'(brk_q) + grow32 - 32'(need_q)) : 32'(brk_q);
	assign bsize_g  = gsplit ? need_q : grow32[16:0];

	// successor search: smallest (start, index) above the previous one
	assign gt = first_q || (rd_start > prev_s_q) ||
		((rd_start == prev_s_q) && (rd_idx_s1 > prev_idx_q));
	assign better = (state_q == S_CO_FIND) && rd_v_s1 && gt &&
		(!best_v_q || (rd_start < best_s_q) ||
		((rd_start == best_s_q) && (rd_idx_s1 < best_idx_q)));
	assign b_v   = better || best_v_q;
	assign b_s   = better ? rd_start : best_s_q;
	assign b_z   = better ? rd_size : best_z_q;
	assign b_idx = better ? rd_idx_s1 : best_idx_q;
	assign cur_end = {2'b00, cur_s_q} + {1'b0, cur_z_q};
	assign adj     = cur_end == {2'b00, b_s};
	assign msum    = {1'b0, cur_z_q} + {1'b0, b_z};
	assign msat    = msum[17] ? '1 : msum[16:0];

	assign scanning = (state_q == S_ALLOC_SCAN) || (state_q == S_ALLOC_SHIFT) ||
		(state_q == S_CO_FIND) || (state_q == S_CO_PACK);
	assign issue    = scanning && (scan_q < cnt_q) && !hit;

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = cnt_q[IDX_W-1:0];
		ent_wdata = {fstart_q, hdr_rdata};
		ent_raddr = (state_q == S_READ_RD) ? idx_q : scan_q[IDX_W-1:0];
		hdr_we    = 1'b0;
		hidx      = bstart_g >> 3;
		hdr_wdata = bsize_g;
		hdr_raddr = fstart_q[15:3];
		unique case (state_q)
			S_ALLOC_SCAN: begin
				hidx      = bstart_h >> 3;
				hdr_wdata = hsplit ? need_q : rd_size;
				hdr_we    = hit && (hidx < HDR_DEPTH);
				ent_we    = hit && hsplit;
				ent_waddr = rd_idx_s1;
				ent_wdata = {rd_start, rem};
			end
			S_ALLOC_SHIFT: begin
				ent_we    = rd_v_s1;
				ent_waddr = rd_idx_s1 - 1'b1;
				ent_wdata = ent_rdata;
			end
			S_ALLOC_GROW: begin
				hdr_we    = !over && !gfull && (hidx < HDR_DEPTH);
				ent_we    = !over && gsplit && !gfull;
				ent_wdata = {brk_q[15:0], 17'(grow32 - 32'(need_q))};
			end
			S_FREE_WR: begin
				ent_we = 1'b1;
			end
			S_CO_FIND: begin
				// close the current run when the walk ends or the chain breaks
				ent_we    = last && (!b_v || (!first_q && !adj));
				ent_waddr = cur_idx_q;
				ent_wdata = {cur_s_q, cur_z_q};
			end
			S_CO_PACK: begin
				ent_we    = rd_v_s1 && keep_q[rd_idx_s1];
				ent_waddr = wr_ptr_q[IDX_W-1:0];
				ent_wdata = ent_rdata;
			end
			default: begin
			end
		endcase
		hdr_waddr = hidx[HDR_AW-1:0];
	end

	ffa_ram #(.WIDTH(ENT_W), .DEPTH(FREE_SLOTS)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	ffa_ram #(.WIDTH(SIZE_W), .DEPTH(HDR_DEPTH)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (hdr_waddr),
		.wdata (hdr_wdata),
		.raddr (hdr_raddr),
		.rdata (hdr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			brk_q       <= '0;
			limit_q     <= 17'h10000;
			scan_q      <= '0;
			rd_v_s1     <= 1'b0;
			first_q     <= 1'b0;
			best_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			rd_v_s1   <= issue;
			rd_idx_s1 <= scan_q[IDX_W-1:0];
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						r_addr_q  <= '0;
						r_bytes_q <= '0;
						r_valid_q <= 1'b0;
						r_stat_q  <= ST_OK;
						scan_q    <= '0;
						need_q    <= need32[16:0];
						fstart_q  <= user_address - 16'd8;
						idx_q     <= list_index[IDX_W-1:0];
						unique case (action_t'(action))
							ACT_ALLOC: begin
								state_q <= (cnt_q == '0) ? S_ALLOC_GROW : S_ALLOC_SCAN;
							end
							ACT_FREE: begin
								priority if (user_address < 16'd8 || fidx >= HDR_DEPTH) begin
									state_q <= S_DONE;
								end else if (cnt32 >= FREE_SLOTS) begin
									r_stat_q <= ST_TABLE_FULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_FREE_RD;
								end
							end
							ACT_COALESCE: begin
								first_q  <= 1'b1;
								best_v_q <= 1'b0;
								keep_q   <= '1;
								state_q  <= (cnt32 < 2) ? S_DONE : S_CO_FIND;
							end
							ACT_READ: begin
								state_q <= (32'(list_index) < cnt32 &&
									32'(list_index) < FREE_SLOTS) ? S_READ_RD : S_DONE;
							end
						endcase
					end
				end
				S_ALLOC_SCAN: begin
					if (hit) begin
						r_addr_q  <= 16'(bstart_h + 32'd8);
						r_bytes_q <= hsplit ? need_q : rd_size;
						priority if (hsplit) begin
							state_q <= S_DONE;
						end else if (last) begin
							cnt_q   <= cnt_m1;
							state_q <= S_DONE;
						end else begin
							// close the gap: move later entries down one place
							scan_q  <= CNT_W'(rd_idx_s1) + 1'b1;
							state_q <= S_ALLOC_SHIFT;
						end
					end else if (last) begin
						state_q <= S_ALLOC_GROW;
					end
				end
				S_ALLOC_SHIFT: begin
					if (last) begin
						cnt_q   <= cnt_m1;
						state_q <= S_DONE;
					end
				end
				S_ALLOC_GROW: begin
					priority if (over) begin
						r_stat_q <= ST_EXHAUSTED;
					end else if (gfull) begin
						r_stat_q <= ST_TABLE_FULL;
					end else begin
						brk_q     <= BRK_W'(32'(brk_q) + grow32);
						r_addr_q  <= 16'(bstart_g + 32'd8);
						r_bytes_q <= bsize_g;
						if (gsplit) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_DONE;
				end
				S_READ_RD: begin
					state_q <= S_READ_WR;
				end
				S_READ_WR: begin
					r_addr_q  <= rd_start;
					r_bytes_q <= rd_size;
					r_valid_q <= 1'b1;
					state_q   <= S_DONE;
				end
				S_CO_FIND: begin
					if (rd_v_s1) begin
						best_v_q   <= b_v;
						best_s_q   <= b_s;
						best_z_q   <= b_z;
						best_idx_q <= b_idx;
					end
					if (last) begin
						if (!b_v) begin
							// walk done: compact the kept entries
							wr_ptr_q <= '0;
							scan_q   <= '0;
							state_q  <= S_CO_PACK;
						end else begin
							if (!first_q && adj) begin
								cur_z_q       <= msat;
								keep_q[b_idx] <= 1'b0;
							end else begin
								cur_s_q   <= b_s;
								cur_z_q   <= b_z;
								cur_idx_q <= b_idx;
							end
							prev_s_q   <= b_s;
							prev_idx_q <= b_idx;
							first_q    <= 1'b0;
							best_v_q   <= 1'b0;
							scan_q     <= '0;
						end
					end
				end
				S_CO_PACK: begin
					if (rd_v_s1 && keep_q[rd_idx_s1]) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end
					if (last) begin
						cnt_q   <= wr_ptr_q + CNT_W'(keep_q[rd_idx_s1]);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						o_addr_q    <= r_addr_q;
						o_bytes_q   <= r_bytes_q;
						o_valid_q   <= r_valid_q;
						o_stat_q    <= r_stat_q;
						o_free_q    <= cnt32[6:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready       = state_q == S_IDLE;
	assign out_valid      = out_valid_q;
	assign result_address = o_addr_q;
	assign result_bytes   = o_bytes_q;
	assign entry_valid    = o_valid_q;
	assign status         = o_stat_q;
	assign free_entries   = o_free_q;
endmodule
`default_nettype wire

// File: rtl/ffa_chk.sv
// port-level checker for the allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ffa_chk
	import ffa_pkg::*;
#(
	parameter int FREE_SLOTS = FREE_SLOTS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] result_address,
	input wire logic [16:0] result_bytes,
	input wire logic        entry_valid,
	input wire logic [1:0]  status,
	input wire logic [6:0]  free_entries
);
	`FFA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(result_address) && $stable(status), "result dropped or changed while stalled")
	`FFA_ASSERT_IMPL(a_read_ok, out_valid && entry_valid, status == ST_OK, "valid entry with error status")
	`FFA_ASSERT_IMPL(a_err_zero, out_valid && status != ST_OK, result_address == 16'd0 && result_bytes == 17'd0, "error result carries data")
	`FFA_ASSERT_IMPL(a_count, out_valid, 32'(free_entries) <= FREE_SLOTS, "free entry count beyond table")
endmodule

bind first_fit_free_list_allocator ffa_chk #(.FREE_SLOTS(FREE_SLOTS)) u_ffa_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.result_address (result_address),
	.result_bytes   (result_bytes),
	.entry_valid    (entry_valid),
	.status         (status),
	.free_entries   (free_entries)
);
`default_nettype wire
